FILE: hw/rtl/fcau_pkg.sv
// ----------------------------------------------------------------------------
// fcau_pkg
// Types, word codes and sizes shared by the Forth cell arithmetic unit.
// ----------------------------------------------------------------------------
package fcau_pkg;

	localparam int CELL_BITS = 32;
	localparam int DBL_BITS = 2 * CELL_BITS;
	localparam int DIV_STEP_BITS = 4;
	localparam int DIV_STAGES = DBL_BITS / DIV_STEP_BITS;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_M_MUL = 5'd3,
		OP_UM_MUL = 5'd4, OP_DIV = 5'd5, OP_MOD = 5'd6, OP_DIVMOD = 5'd7,
		OP_UDIVMOD = 5'd8, OP_SMREM = 5'd9, OP_FMMOD = 5'd10, OP_MULDIV = 5'd11,
		OP_MULDIVMOD = 5'd12, OP_INC = 5'd13, OP_DEC = 5'd14, OP_DBL = 5'd15,
		OP_HALF = 5'd16, OP_ABS = 5'd17, OP_NEGATE = 5'd18, OP_MIN = 5'd19,
		OP_MAX = 5'd20
	} op_e;

	typedef struct packed {
		logic [4:0] op;
		logic [31:0] cell_a;
		logic [31:0] cell_b;
		logic [31:0] cell_c;
		logic signed [63:0] double_dividend;
		logic logic_op;
	} req_t;

	typedef struct packed {
		logic [31:0] first_cell;
		logic [31:0] second_cell;
		logic [1:0] cell_count;
		logic divide_by_zero;
		logic quotient_overflow;
	} rsp_t;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] cnt;
		logic dz;
		logic qneg;
		logic nneg;
		logic dneg;
		logic [CELL_BITS-1:0] simple;
	} ctl_t;

	typedef struct packed {
		ctl_t ctl;
		logic [DBL_BITS-1:0] prod;
		logic [DBL_BITS-1:0] nq;
		logic [CELL_BITS:0] rem;
		logic [CELL_BITS-1:0] dmag;
	} pipe_t;

	function automatic logic [CELL_BITS-1:0] mag_of(input logic [CELL_BITS-1:0] v);
		mag_of = v[CELL_BITS-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

FILE: hw/rtl/forth_cell_arithmetic_unit_top.sv
// Pipeline from start to done: 3 front stages, 16 divider stages, 2 back stages.
// Throughput: one word per cycle; busy is always low and every word takes the full pipeline.
// Most of the depth is the 16-stage restoring divider, four quotient bits per stage.
// Reset clears all valid bits at once; no word is lost to a stalled receiver, since none stalls.
// ----------------------------------------------------------------------------
// forth_cell_arithmetic_unit_top
// Pipelined arithmetic unit for Forth integer stack words.
// ----------------------------------------------------------------------------
module forth_cell_arithmetic_unit_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input fcau_pkg::req_t req,
	output logic done,
	output fcau_pkg::rsp_t rsp
);
	import fcau_pkg::*;

	logic valid_d [0:DIV_STAGES];
	pipe_t pipe_d [0:DIV_STAGES];

	assign busy = 1'b0;

	fcau_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.valid_i(start && !busy),
		.req_i(req),
		.valid_o(valid_d[0]),
		.pipe_o(pipe_d[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		fcau_div_stage u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.valid_i(valid_d[g]),
			.pipe_i(pipe_d[g]),
			.valid_o(valid_d[g+1]),
			.pipe_o(pipe_d[g+1])
		);
	end

	fcau_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.valid_i(valid_d[DIV_STAGES]),
		.pipe_i(pipe_d[DIV_STAGES]),
		.done(done),
		.rsp(rsp)
	);

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.cell_count == 2'd1 || rsp.cell_count == 2'd2))
		else $error("cell count out of range");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.divide_by_zero || rsp.quotient_overflow)) |->
		(rsp.first_cell == '0 && rsp.second_cell == '0))
		else $error("flagged result not forced to zero");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.divide_by_zero && rsp.quotient_overflow))
		else $error("both error flags set");

endmodule

FILE: hw/rtl/fcau_front.sv
// ----------------------------------------------------------------------------
// fcau_front
// Decode, simple words, the cell multiplier and the divider setup, three stages.
// ----------------------------------------------------------------------------
module fcau_front (
	input logic clk,
	input logic arst_n,
	input logic valid_i,
	input fcau_pkg::req_t req_i,
	output logic valid_o,
	output fcau_pkg::pipe_t pipe_o
);
	import fcau_pkg::*;

	logic [CELL_BITS-1:0] a, b, c, ma, mb, mc;
	logic na, nb, nc, dneg_dd;
	logic [DBL_BITS-1:0] dd, dmag_dd;
	ctl_t ctl;
	logic [CELL_BITS-1:0] mula, mulb, dmag;
	logic [DBL_BITS-1:0] num;

	logic valid_s1, valid_s2, valid_s3;
	ctl_t ctl_s1, ctl_s2;
	logic [CELL_BITS-1:0] mula_s1, mulb_s1, dmag_s1, dmag_s2;
	logic [DBL_BITS-1:0] num_s1, num_s2, prod_s2;
	pipe_t pipe_s3;
	logic [DBL_BITS-1:0] prod_fix;

	always_comb begin
		a = req_i.cell_a[CELL_BITS-1:0];
		b = req_i.cell_b[CELL_BITS-1:0];
		c = req_i.cell_c[CELL_BITS-1:0];
		na = a[CELL_BITS-1];
		nb = b[CELL_BITS-1];
		nc = c[CELL_BITS-1];
		ma = mag_of(a);
		mb = mag_of(b);
		mc = mag_of(c);
		dd = req_i.double_dividend[DBL_BITS-1:0];
		dneg_dd = dd[DBL_BITS-1];
		dmag_dd = dneg_dd ? (~dd + 1'b1) : dd;
		ctl = '0;
		ctl.op = req_i.op;
		ctl.cnt = 2'd1;
		mula = ma;
		mulb = mb;
		dmag = mb;
		num = {{CELL_BITS{1'b0}}, ma};
		case (req_i.op)
			OP_ADD: begin
				ctl.simple = req_i.logic_op ? ~a : a + b;
			end
			OP_SUB: begin
				ctl.simple = req_i.logic_op ? (a ^ b) : a - b;
			end
			OP_MUL: begin
				mula = a;
				mulb = b;
			end
			OP_M_MUL: begin
				ctl.cnt = 2'd2;
				ctl.qneg = na ^ nb;
			end
			OP_UM_MUL: begin
				ctl.cnt = 2'd2;
				mula = a;
				mulb = b;
			end
			OP_DIV, OP_MOD, OP_DIVMOD: begin
				ctl.cnt = (req_i.op == OP_DIVMOD) ? 2'd2 : 2'd1;
				ctl.dz = (b == '0);
				ctl.nneg = na;
				ctl.dneg = nb;
				ctl.qneg = na ^ nb;
			end
			OP_UDIVMOD: begin
				ctl.cnt = 2'd2;
				ctl.dz = (b == '0);
				dmag = b;
				num = {{CELL_BITS{1'b0}}, a};
			end
			OP_SMREM, OP_FMMOD: begin
				ctl.cnt = 2'd2;
				ctl.dz = (c == '0);
				ctl.nneg = dneg_dd;
				ctl.dneg = nc;
				ctl.qneg = dneg_dd ^ nc;
				dmag = mc;
				num = dmag_dd;
			end
			OP_MULDIV, OP_MULDIVMOD: begin
				ctl.cnt = (req_i.op == OP_MULDIVMOD) ? 2'd2 : 2'd1;
				ctl.dz = (c == '0);
				ctl.nneg = na ^ nb;
				ctl.dneg = nc;
				ctl.qneg = na ^ nb ^ nc;
				dmag = mc;
			end
			OP_INC: ctl.simple = a + 1'b1;
			OP_DEC: ctl.simple = a - 1'b1;
			OP_DBL: ctl.simple = {a[CELL_BITS-2:0], 1'b0};
			OP_HALF: begin
				ctl.simple = na ? (~(ma >> 1) + 1'b1) : (ma >> 1);
			end
			OP_ABS: ctl.simple = ma;
			OP_NEGATE: ctl.simple = ~a + 1'b1;
			OP_MIN: ctl.simple = ($signed(a) < $signed(b)) ? a : b;
			OP_MAX: ctl.simple = ($signed(a) > $signed(b)) ? a : b;
			default: ctl.simple = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl;
		mula_s1 <= mula;
		mulb_s1 <= mulb;
		dmag_s1 <= dmag;
		num_s1 <= num;
		ctl_s2 <= ctl_s1;
		dmag_s2 <= dmag_s1;
		num_s2 <= num_s1;
		prod_s2 <= DBL_BITS'(mula_s1) * DBL_BITS'(mulb_s1);
	end

	always_comb begin
		prod_fix = prod_s2;
		if (ctl_s2.op == OP_M_MUL && ctl_s2.qneg) begin
			prod_fix = ~prod_s2 + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		pipe_s3.ctl <= ctl_s2;
		pipe_s3.prod <= prod_fix;
		pipe_s3.nq <= (ctl_s2.op == OP_MULDIV || ctl_s2.op == OP_MULDIVMOD) ?
			prod_s2 : num_s2;
		pipe_s3.rem <= '0;
		pipe_s3.dmag <= dmag_s2;
	end

	assign valid_o = valid_s3;
	assign pipe_o = pipe_s3;

endmodule

FILE: hw/rtl/fcau_div_stage.sv
// ----------------------------------------------------------------------------
// fcau_div_stage
// One register stage of the restoring divider, retiring four quotient bits.
// ----------------------------------------------------------------------------
module fcau_div_stage (
	input logic clk,
	input logic arst_n,
	input logic valid_i,
	input fcau_pkg::pipe_t pipe_i,
	output logic valid_o,
	output fcau_pkg::pipe_t pipe_o
);
	import fcau_pkg::*;

	logic [CELL_BITS:0] rem;
	logic [DBL_BITS-1:0] nq;
	logic valid_sd;
	pipe_t pipe_sd;

	always_comb begin
		rem = pipe_i.rem;
		nq = pipe_i.nq;
		for (int i = 0; i < DIV_STEP_BITS; i++) begin
			rem = {rem[CELL_BITS-1:0], nq[DBL_BITS-1]};
			nq = {nq[DBL_BITS-2:0], 1'b0};
			if (rem >= {1'b0, pipe_i.dmag}) begin
				rem = rem - {1'b0, pipe_i.dmag};
				nq[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd <= 1'b0;
		end else begin
			valid_sd <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		pipe_sd.ctl <= pipe_i.ctl;
		pipe_sd.prod <= pipe_i.prod;
		pipe_sd.dmag <= pipe_i.dmag;
		pipe_sd.rem <= rem;
		pipe_sd.nq <= nq;
	end

	assign valid_o = valid_sd;
	assign pipe_o = pipe_sd;

endmodule

FILE: hw/rtl/fcau_back.sv
// ----------------------------------------------------------------------------
// fcau_back
// Floored correction, overflow check, sign fix and result selection.
// ----------------------------------------------------------------------------
module fcau_back (
	input logic clk,
	input logic arst_n,
	input logic valid_i,
	input fcau_pkg::pipe_t pipe_i,
	output logic done,
	output fcau_pkg::rsp_t rsp
);
	import fcau_pkg::*;

	localparam logic [DBL_BITS-1:0] HALF = DBL_BITS'(1) << (CELL_BITS - 1);

	logic [DBL_BITS-1:0] q;
	logic [CELL_BITS-1:0] r;
	logic rneg, ovf, sdiv;

	logic valid_f1, valid_f2;
	ctl_t ctl_f1;
	logic [DBL_BITS-1:0] prod_f1;
	logic [CELL_BITS-1:0] q_f1, r_f1;
	logic rneg_f1, ovf_f1;
	logic [CELL_BITS-1:0] quo, rmd;
	rsp_t rsp_n, rsp_f2;

	always_comb begin
		q = pipe_i.nq;
		r = pipe_i.rem[CELL_BITS-1:0];
		rneg = pipe_i.ctl.nneg;
		if (pipe_i.ctl.op == OP_FMMOD && r != '0 && pipe_i.ctl.qneg) begin
			q = q + 1'b1;
			r = pipe_i.dmag - r;
			rneg = pipe_i.ctl.dneg;
		end
		sdiv = (pipe_i.ctl.op == OP_DIV) || (pipe_i.ctl.op == OP_DIVMOD) ||
			(pipe_i.ctl.op == OP_SMREM) || (pipe_i.ctl.op == OP_FMMOD) ||
			(pipe_i.ctl.op == OP_MULDIV) || (pipe_i.ctl.op == OP_MULDIVMOD);
		ovf = sdiv && !pipe_i.ctl.dz &&
			(pipe_i.ctl.qneg ? (q > HALF) : (q > HALF - 1'b1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_f1 <= 1'b0;
			valid_f2 <= 1'b0;
		end else begin
			valid_f1 <= valid_i;
			valid_f2 <= valid_f1;
		end
	end

	always_ff @(posedge clk) begin
		ctl_f1 <= pipe_i.ctl;
		prod_f1 <= pipe_i.prod;
		q_f1 <= q[CELL_BITS-1:0];
		r_f1 <= r;
		rneg_f1 <= rneg;
		ovf_f1 <= ovf;
	end

	always_comb begin
		quo = ctl_f1.qneg ? (~q_f1 + 1'b1) : q_f1;
		rmd = rneg_f1 ? (~r_f1 + 1'b1) : r_f1;
		rsp_n = '0;
		rsp_n.cell_count = ctl_f1.cnt;
		rsp_n.divide_by_zero = ctl_f1.dz;
		rsp_n.quotient_overflow = ovf_f1;
		case (ctl_f1.op)
			OP_MUL: rsp_n.first_cell = 32'(prod_f1[CELL_BITS-1:0]);
			OP_M_MUL, OP_UM_MUL: begin
				rsp_n.first_cell = 32'(prod_f1[CELL_BITS-1:0]);
				rsp_n.second_cell = 32'(prod_f1[DBL_BITS-1:CELL_BITS]);
			end
			OP_DIV, OP_MULDIV: rsp_n.first_cell = 32'(quo);
			OP_MOD: rsp_n.first_cell = 32'(rmd);
			OP_DIVMOD, OP_UDIVMOD, OP_SMREM, OP_FMMOD, OP_MULDIVMOD: begin
				rsp_n.first_cell = 32'(rmd);
				rsp_n.second_cell = 32'(quo);
			end
			default: rsp_n.first_cell = 32'(ctl_f1.simple);
		endcase
		if (ctl_f1.dz || ovf_f1) begin
			rsp_n.first_cell = '0;
			rsp_n.second_cell = '0;
		end
	end

	always_ff @(posedge clk) begin
		rsp_f2 <= rsp_n;
	end

	assign done = valid_f2;
	assign rsp = rsp_f2;

endmodule
